@@ design/brb_pkg.sv @@
package brb_pkg;

  // Store geometry. The depth is a power of two, so the pointers wrap on their own.
  localparam int PTR_W     = 14;
  localparam int DEPTH     = 1 << PTR_W;
  localparam int BYTE_W    = 8;
  localparam int MODE_W    = 3;
  localparam int CNT_W     = 7;
  localparam int MAX_BURST = 64;

  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE     = 3'd0,
    MODE_DEQUEUE   = 3'd1,
    MODE_PEEK      = 3'd2,
    MODE_ADV_REAR  = 3'd3,
    MODE_ADV_FRONT = 3'd4,
    MODE_CLEAR     = 3'd5,
    MODE_STATUS    = 3'd6
  } mode_t;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic accept;  // take the input beat and apply its pointer update
    logic load;    // load the next result beat into the output register
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_free;   // output register empties this cycle or is empty
    logic last_beat;  // the beat about to be loaded closes the item
  } dp_stat_t;

endpackage

@@ design/brb_if.sv @@
interface brb_in_if;
  import brb_pkg::*;

  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [BYTE_W-1:0]   data_byte;
  logic [CNT_W-1:0]    count;

  modport source (output valid, mode, data_byte, count, input ready);
  modport sink   (input valid, mode, data_byte, count, output ready);
endinterface

interface brb_out_if;
  import brb_pkg::*;

  logic                valid;
  logic                ready;
  logic [BYTE_W-1:0]   byte_out;
  logic                byte_valid;
  logic                last_of_run;
  logic [CNT_W-1:0]    moved;
  logic [PTR_W-1:0]    used_count;
  logic [PTR_W-1:0]    free_count;
  logic [PTR_W-1:0]    direct_write_span;
  logic [PTR_W-1:0]    direct_read_span;

  modport source (output valid, byte_out, byte_valid, last_of_run, moved, used_count,
                  free_count, direct_write_span, direct_read_span, input ready);
  modport sink   (input valid, byte_out, byte_valid, last_of_run, moved, used_count,
                  free_count, direct_write_span, direct_read_span, output ready);
endinterface

@@ design/byte_ring_buffer_fifo.sv @@
// Circular byte FIFO of 16384 bytes that always keeps one slot free, so it holds at most
// 16383 bytes. Each input beat carries a mode: write one byte (dropped when full), dequeue
// or peek up to count bytes (count saturates at 64 and is cut to the bytes held), advance
// the rear or front pointer by the saturated count without any check, clear both
// pointers, or report status. A dequeue or peek of n > 0 bytes returns n result beats,
// one byte each; every other item, an empty read included, returns one beat. Every beat
// reports the fill state after the operation. The block takes one item at a time: an item
// first goes through the pointer update and then emits its result beats. Read bytes
// stream at one per cycle while the sink keeps ready high, because the synchronous RAM
// read register loads in step with the output register. The output register holds a
// finished beat while the input side is already free to accept the next item. Bytes that
// were never written read back as unknown values.
module byte_ring_buffer_fifo
  import brb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  brb_in_if.sink    in_ch,
  brb_out_if.source out_ch
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // The controller sequences accept and beat emission; it sees only the input valid,
  // the output register's room and whether the beat being loaded closes the item.
  brb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the pointers, the byte store, the burst counter and the output
  // register with its status fields.
  brb_datapath u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .stat                  (stat),
    .in_mode               (in_ch.mode),
    .in_data_byte          (in_ch.data_byte),
    .in_count              (in_ch.count),
    .out_ready             (out_ch.ready),
    .out_valid             (out_ch.valid),
    .out_byte_out          (out_ch.byte_out),
    .out_byte_valid        (out_ch.byte_valid),
    .out_last_of_run       (out_ch.last_of_run),
    .out_moved             (out_ch.moved),
    .out_used_count        (out_ch.used_count),
    .out_free_count        (out_ch.free_count),
    .out_direct_write_span (out_ch.direct_write_span),
    .out_direct_read_span  (out_ch.direct_read_span)
  );

`ifndef NO_ASSERTIONS
  // One item at a time: an accepted beat is never followed by another in the next cycle.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input accepted while an item was still being emitted");

  // A beat carrying a read byte belongs to a read of at least one byte.
  a_read_moved: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.byte_valid |-> out_ch.moved != '0)
    else $error("read byte reported with nothing moved");

  // A beat without a byte always closes its item.
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.byte_valid |-> out_ch.last_of_run)
    else $error("non-read result not marked as last of run");

  // While the controller is emitting, the input side stays closed until the last beat.
  a_closed_until_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && !out_ch.last_of_run |-> !in_ch.ready)
    else $error("input reopened in the middle of a burst");
`endif

endmodule

@@ design/brb_ram.sv @@
module brb_ram #(
  parameter int ADDR_W = 14,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [(1 << ADDR_W)];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ design/brb_ctrl.sv @@
module brb_ctrl
  import brb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat.out_free && stat.last_beat) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd.accept = 1'b0;
    cmd.load   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_EMIT: begin
        cmd.load = stat.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

@@ design/brb_datapath.sv @@
module brb_datapath
  import brb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  ctrl_cmd_t         cmd,
  output dp_stat_t          stat,
  input  logic [MODE_W-1:0] in_mode,
  input  logic [BYTE_W-1:0] in_data_byte,
  input  logic [CNT_W-1:0]  in_count,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [BYTE_W-1:0] out_byte_out,
  output logic              out_byte_valid,
  output logic              out_last_of_run,
  output logic [CNT_W-1:0]  out_moved,
  output logic [PTR_W-1:0]  out_used_count,
  output logic [PTR_W-1:0]  out_free_count,
  output logic [PTR_W-1:0]  out_direct_write_span,
  output logic [PTR_W-1:0]  out_direct_read_span
);

  logic [PTR_W-1:0]  rp_r, rp_nxt, wp_r, wp_nxt;
  logic [PTR_W-1:0]  addr_r, addr_nxt;
  logic [CNT_W-1:0]  remain_r, remain_nxt;
  logic [CNT_W-1:0]  moved_r, moved_nxt;
  logic              rd_item_r, rd_item_nxt;

  logic              ov_r;
  logic              obv_r, olast_r;
  logic [CNT_W-1:0]  omoved_r;
  logic [PTR_W-1:0]  oused_r, owspan_r, orspan_r;

  logic [PTR_W-1:0]  used_now, wspan_now, rspan_now;
  logic [CNT_W-1:0]  cnt_sat, n_read;
  logic              wr_en, rd_en;
  logic [BYTE_W-1:0] rd_data;

  // Fill state of the current pointers; all sums wrap modulo the depth.
  always_comb begin
    used_now = wp_r - rp_r;
    if (wp_r >= rp_r) begin
      wspan_now = PTR_W'(0) - wp_r - PTR_W'(rp_r == '0);
      rspan_now = wp_r - rp_r;
    end else begin
      wspan_now = rp_r - wp_r - PTR_W'(1);
      rspan_now = PTR_W'(0) - rp_r;
    end
  end

  always_comb begin
    cnt_sat = (in_count > CNT_W'(MAX_BURST)) ? CNT_W'(MAX_BURST) : in_count;
    n_read  = (PTR_W'(cnt_sat) < used_now) ? cnt_sat : used_now[CNT_W-1:0];
  end

  always_comb begin
    rp_nxt      = rp_r;
    wp_nxt      = wp_r;
    addr_nxt    = addr_r;
    remain_nxt  = remain_r;
    moved_nxt   = moved_r;
    rd_item_nxt = rd_item_r;
    wr_en       = 1'b0;
    if (cmd.accept) begin
      addr_nxt    = rp_r;
      remain_nxt  = CNT_W'(1);
      moved_nxt   = '0;
      rd_item_nxt = 1'b0;
      unique case (mode_t'(in_mode))
        MODE_WRITE: begin
          if (used_now != '1) begin
            wr_en     = 1'b1;
            wp_nxt    = wp_r + PTR_W'(1);
            moved_nxt = CNT_W'(1);
          end
        end
        MODE_DEQUEUE, MODE_PEEK: begin
          if (n_read != '0) begin
            remain_nxt  = n_read;
            moved_nxt   = n_read;
            rd_item_nxt = 1'b1;
            if (mode_t'(in_mode) == MODE_DEQUEUE) begin
              rp_nxt = rp_r + PTR_W'(n_read);
            end
          end
        end
        MODE_ADV_REAR: begin
          wp_nxt    = wp_r + PTR_W'(cnt_sat);
          moved_nxt = cnt_sat;
        end
        MODE_ADV_FRONT: begin
          rp_nxt    = rp_r + PTR_W'(cnt_sat);
          moved_nxt = cnt_sat;
        end
        MODE_CLEAR: begin
          rp_nxt = '0;
          wp_nxt = '0;
        end
        default: begin
          moved_nxt = '0;
        end
      endcase
    end else if (cmd.load) begin
      addr_nxt   = addr_r + PTR_W'(1);
      remain_nxt = remain_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r      <= '0;
      wp_r      <= '0;
      remain_r  <= '0;
      rd_item_r <= 1'b0;
    end else begin
      rp_r      <= rp_nxt;
      wp_r      <= wp_nxt;
      remain_r  <= remain_nxt;
      rd_item_r <= rd_item_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r  <= addr_nxt;
    moved_r <= moved_nxt;
  end

  assign rd_en = cmd.load && rd_item_r;

  brb_ram #(
    .ADDR_W (PTR_W),
    .DATA_W (BYTE_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wp_r),
    .wr_data (in_data_byte),
    .rd_en   (rd_en),
    .rd_addr (addr_r),
    .rd_data (rd_data)
  );

  // Output register: the read data register of the RAM loads together with it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.load) begin
      ov_r <= 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      obv_r    <= rd_item_r;
      olast_r  <= (remain_r == CNT_W'(1));
      omoved_r <= moved_r;
      oused_r  <= used_now;
      owspan_r <= wspan_now;
      orspan_r <= rspan_now;
    end
  end

  assign stat.out_free  = !ov_r || out_ready;
  assign stat.last_beat = (remain_r == CNT_W'(1));

  assign out_valid             = ov_r;
  assign out_byte_out          = obv_r ? rd_data : '0;
  assign out_byte_valid        = obv_r;
  assign out_last_of_run       = olast_r;
  assign out_moved             = omoved_r;
  assign out_used_count        = oused_r;
  assign out_free_count        = ~oused_r;
  assign out_direct_write_span = owspan_r;
  assign out_direct_read_span  = orspan_r;

endmodule
